// ----- rtl/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned HDR_CNT_W  = 3;

  localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 4096;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 13'd4096;

  typedef enum logic {
    CMD_FEED    = 1'b0,
    CMD_CONSUME = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_NEED_MORE = 2'd0,
    STATUS_READY     = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [BYTE_W-1:0] data_byte;
  } lpd_in_t;

  typedef struct packed {
    status_e           status;
    logic              accepted;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  payload_index;
    logic [LEN_W-1:0]  payload_length;
    logic              frame_end;
  } lpd_out_t;

endpackage

// ----- rtl/lpd_core.sv -----
// ----------------------------------------------------------------------------
// lpd_core
// Decoder state, length limit register and the per-byte result logic.
// ----------------------------------------------------------------------------
module lpd_core #(
  parameter int unsigned MaxFrameBytes = lpd_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  lpd_pkg::lpd_in_t         item_i,
  input  logic                     cfg_we_i,
  input  logic [lpd_pkg::LEN_W-1:0] cfg_wdata_i,
  output lpd_pkg::lpd_out_t        result_o
);

  localparam int unsigned LenMax = (1 << lpd_pkg::LEN_W) - 1;
  localparam logic [lpd_pkg::LEN_W-1:0] CapBytes =
    lpd_pkg::LEN_W'((MaxFrameBytes > LenMax) ? LenMax : MaxFrameBytes);
  localparam int unsigned WideW = lpd_pkg::LEN_W + lpd_pkg::BYTE_W;

  logic [lpd_pkg::LEN_W-1:0]     max_len_q;
  logic [lpd_pkg::HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [lpd_pkg::LEN_W-1:0]     shift_q, shift_d;
  logic                          big_q, big_d;
  logic [lpd_pkg::LEN_W-1:0]     frame_len_q, frame_len_d;
  logic [lpd_pkg::LEN_W-1:0]     rcv_q, rcv_d;
  logic                          ready_q, ready_d;

  logic [lpd_pkg::LEN_W-1:0] limit;
  logic [WideW-1:0]          wide;
  logic                      big_next;

  assign limit    = (max_len_q < CapBytes) ? max_len_q : CapBytes;
  assign wide     = {shift_q, item_i.data_byte};
  assign big_next = big_q | (|wide[WideW-1:lpd_pkg::LEN_W]);

  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    shift_d     = shift_q;
    big_d       = big_q;
    frame_len_d = frame_len_q;
    rcv_d       = rcv_q;
    ready_d     = ready_q;
    result_o    = '0;
    result_o.status = lpd_pkg::STATUS_NEED_MORE;

    if (item_i.command == lpd_pkg::CMD_CONSUME) begin
      hdr_cnt_d   = '0;
      shift_d     = '0;
      big_d       = 1'b0;
      frame_len_d = '0;
      rcv_d       = '0;
      ready_d     = 1'b0;
    end else if (ready_q) begin
      result_o.status         = lpd_pkg::STATUS_READY;
      result_o.payload_length = frame_len_q;
    end else if (hdr_cnt_q != lpd_pkg::HDR_CNT_W'(lpd_pkg::HDR_BYTES)) begin
      result_o.accepted = 1'b1;
      shift_d   = wide[lpd_pkg::LEN_W-1:0];
      big_d     = big_next;
      hdr_cnt_d = hdr_cnt_q + 1'b1;
      if (hdr_cnt_q == lpd_pkg::HDR_CNT_W'(lpd_pkg::HDR_BYTES - 1)) begin
        if (big_next || (shift_d == '0) || (shift_d > limit)) begin
          hdr_cnt_d   = '0;
          shift_d     = '0;
          big_d       = 1'b0;
          frame_len_d = '0;
          rcv_d       = '0;
          ready_d     = 1'b0;
          result_o.status = lpd_pkg::STATUS_MALFORMED;
        end else begin
          frame_len_d             = shift_d;
          rcv_d                   = '0;
          result_o.payload_length = shift_d;
        end
      end
    end else begin
      result_o.accepted       = 1'b1;
      result_o.payload_valid  = 1'b1;
      result_o.payload_byte   = item_i.data_byte;
      result_o.payload_index  = rcv_q[lpd_pkg::IDX_W-1:0];
      result_o.payload_length = frame_len_q;
      rcv_d = rcv_q + 1'b1;
      if (rcv_d >= frame_len_q) begin
        ready_d            = 1'b1;
        result_o.status    = lpd_pkg::STATUS_READY;
        result_o.frame_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= lpd_pkg::MAX_PAYLOAD_RESET;
      hdr_cnt_q   <= '0;
      shift_q     <= '0;
      big_q       <= 1'b0;
      frame_len_q <= '0;
      rcv_q       <= '0;
      ready_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        hdr_cnt_q   <= hdr_cnt_d;
        shift_q     <= shift_d;
        big_q       <= big_d;
        frame_len_q <= frame_len_d;
        rcv_q       <= rcv_d;
        ready_q     <= ready_d;
      end
    end
  end

endmodule

// ----- rtl/lpd_out_reg.sv -----
// ----------------------------------------------------------------------------
// lpd_out_reg
// Result register with valid/stall handshake toward the downstream side.
// ----------------------------------------------------------------------------
module lpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpd_pkg::lpd_out_t result_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpd_pkg::lpd_out_t out_data_o
);

  logic              valid_q;
  lpd_pkg::lpd_out_t data_q;
  logic              load;

  assign in_stall_o  = valid_q & out_stall_i;
  assign load        = in_valid_i & ~in_stall_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

endmodule

// ----- rtl/length_prefix_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Byte-stream deframer for a 32-bit big-endian length prefix.
// ----------------------------------------------------------------------------
// One byte or consume command is taken per cycle while the output side does
// not stall, and each transaction yields exactly one result, visible in the
// output register on the cycle after it is accepted. The decoder state update
// and the result are computed combinationally between the state registers and
// the output register, so the block sustains one transaction per clock. A
// stalled output holds its result and stalls the input in the same cycle. The
// length limit is the smaller of the configuration register and MaxFrameBytes;
// it should be written only while no transaction is in flight.
module length_prefix_deframer #(
  parameter int unsigned MaxFrameBytes = lpd_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lpd_pkg::lpd_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lpd_pkg::lpd_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [lpd_pkg::LEN_W-1:0] cfg_wdata_i
);

  lpd_pkg::lpd_out_t result;
  logic              fire;

  assign fire = in_valid_i & ~in_stall_o;

  lpd_core #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result)
  );

  lpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
